// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
// Clock and reset names follow the project convention (i_clk, i_rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ifsf_pkg.sv -----
// Types and constants for the information-frame stuffing framer.
// No dependencies; used by ifsf_builder, ifsf_serializer, the top level and the testbench.
package ifsf_pkg;

    localparam logic [7:0] FLAG_BYTE    = 8'h7E;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_XOR      = 8'h20;
    localparam logic [7:0] ADDR_RESET   = 8'h03;
    localparam int         MAX_RESULTS  = 9;
    localparam int         CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int         IDX_W        = $clog2(MAX_RESULTS);

    // Item kinds on the input channel
    localparam logic ACT_PAYLOAD = 1'b0;
    localparam logic ACT_ACK     = 1'b1;

    typedef logic [7:0] t_cfg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last_payload;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } t_out_item;

    // One line byte waiting in the result buffer
    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } t_entry;

    // Builder to serializer: a full result set for one payload transaction
    typedef struct packed {
        logic                             load;
        logic [CNT_W-1:0]                 cnt;
        t_entry [MAX_RESULTS-1:0]         ent;
    } t_load;

endpackage

// ----- hdl/ifsf_chan_if.sv -----
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; instantiated with types from ifsf_pkg.
interface ifsf_chan_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ifsf_builder.sv -----
// Frame state and per-transaction result set builder.
// Depends on ifsf_pkg and ifsf_chan_if.
module ifsf_builder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ifsf_chan_if.sink            i_in,
    ifsf_chan_if.sink            i_cfg,
    input  logic                 i_free,
    output ifsf_pkg::t_load      o_load
);

    logic                        r_seq;
    logic [7:0]                  r_acc;
    logic                        r_inside;
    logic [7:0]                  r_addr;
    logic [7:0]                  n_acc;
    logic                        in_take;
    logic                        pay_take;
    logic [7:0]                  ctrl;
    logic [7:0]                  acc_sum;
    logic [ifsf_pkg::CNT_W-1:0]  k;
    ifsf_pkg::t_entry [ifsf_pkg::MAX_RESULTS-1:0] e;

    // Accept input only when the result buffer can take a new set
    assign i_in.ready  = i_free;
    assign i_cfg.ready = 1'b1;
    assign in_take     = i_in.valid && i_in.ready;
    assign pay_take    = in_take && (i_in.data.action == ifsf_pkg::ACT_PAYLOAD);

    // Build header (when opening a frame), stuffed data, and on the last payload stuffed check and closing flag
    always_comb begin
        e       = '0;
        k       = '0;
        ctrl    = {1'b0, r_seq, 6'b0};
        acc_sum = (r_inside ? r_acc : 8'h00) ^ i_in.data.data_byte;
        if (!r_inside) begin
            e[k[ifsf_pkg::IDX_W-1:0]] = '{ifsf_pkg::FLAG_BYTE, 1'b0}; k = k + 1'b1;
            e[k[ifsf_pkg::IDX_W-1:0]] = '{r_addr, 1'b0};              k = k + 1'b1;
            e[k[ifsf_pkg::IDX_W-1:0]] = '{ctrl, 1'b0};                k = k + 1'b1;
            e[k[ifsf_pkg::IDX_W-1:0]] = '{r_addr ^ ctrl, 1'b0};       k = k + 1'b1;
        end
        if (i_in.data.data_byte == ifsf_pkg::FLAG_BYTE ||
            i_in.data.data_byte == ifsf_pkg::ESC_BYTE) begin
            e[k[ifsf_pkg::IDX_W-1:0]] = '{ifsf_pkg::ESC_BYTE, 1'b0};  k = k + 1'b1;
            e[k[ifsf_pkg::IDX_W-1:0]] =
                '{i_in.data.data_byte ^ ifsf_pkg::ESC_XOR, 1'b0};     k = k + 1'b1;
        end else begin
            e[k[ifsf_pkg::IDX_W-1:0]] = '{i_in.data.data_byte, 1'b0}; k = k + 1'b1;
        end
        if (i_in.data.last_payload) begin
            if (acc_sum == ifsf_pkg::FLAG_BYTE || acc_sum == ifsf_pkg::ESC_BYTE) begin
                e[k[ifsf_pkg::IDX_W-1:0]] = '{ifsf_pkg::ESC_BYTE, 1'b0};      k = k + 1'b1;
                e[k[ifsf_pkg::IDX_W-1:0]] = '{acc_sum ^ ifsf_pkg::ESC_XOR, 1'b0};
                k = k + 1'b1;
            end else begin
                e[k[ifsf_pkg::IDX_W-1:0]] = '{acc_sum, 1'b0};                 k = k + 1'b1;
            end
            e[k[ifsf_pkg::IDX_W-1:0]] = '{ifsf_pkg::FLAG_BYTE, 1'b1};         k = k + 1'b1;
        end
        n_acc = i_in.data.last_payload ? 8'h00 : acc_sum;
    end

    assign o_load.load = pay_take;
    assign o_load.cnt  = k;
    assign o_load.ent  = e;

    // Advance frame state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= 1'b0;
            r_acc    <= 8'h00;
            r_inside <= 1'b0;
            r_addr   <= ifsf_pkg::ADDR_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_addr <= i_cfg.data;
            end
            if (in_take && i_in.data.action == ifsf_pkg::ACT_ACK) begin
                r_seq <= ~r_seq;
            end
            if (pay_take) begin
                r_acc    <= n_acc;
                r_inside <= ~i_in.data.last_payload;
            end
        end
    end

endmodule

// ----- hdl/ifsf_serializer.sv -----
// Result buffer that sends one line byte per output transaction.
// Depends on ifsf_pkg and ifsf_chan_if.
module ifsf_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ifsf_pkg::t_load      i_load,
    output logic                 o_free,
    ifsf_chan_if.source          o_out
);

    logic [ifsf_pkg::CNT_W-1:0]                   r_cnt;
    ifsf_pkg::t_entry [ifsf_pkg::MAX_RESULTS-1:0] r_ent;
    logic                                         take;

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.data.out_byte  = r_ent[0].line_byte;
    assign o_out.data.frame_end = r_ent[0].frame_end;
    assign o_out.data.run_last  = (r_cnt == ifsf_pkg::CNT_W'(1));
    assign take                 = o_out.valid && o_out.ready;
    assign o_free = (r_cnt == '0) || (r_cnt == ifsf_pkg::CNT_W'(1) && take);

    // Hold the count; reload or drop one per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load.load) begin
            r_cnt <= i_load.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Load a new set, or shift bytes toward the head
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_ent <= i_load.ent;
        end else if (take) begin
            for (int i = 0; i < ifsf_pkg::MAX_RESULTS - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
    end

endmodule

// ----- hdl/info_frame_stuffing_framer_unit.sv -----
// Top level of the information-frame stuffing framer.
// Depends on ifsf_pkg, ifsf_chan_if, ifsf_builder, ifsf_serializer, assert_macros.svh.
//
//  port    role    payload                                  accepted when
//  i_in    sink    action, data_byte, last_payload          valid && ready
//  o_out   source  out_byte, frame_end, run_last            valid && ready
//  i_cfg   sink    address_byte (8 bits)                    valid && ready (ready always 1)
//
// A payload transaction yields 1 to 9 line bytes, sent one per cycle from the result
// buffer while o_out is ready; the next transaction is taken in the cycle the last byte
// leaves, so no new item, acknowledge or payload, is taken while line bytes remain.
// Reset is synchronous: frame closed, sequence bit 0, address 0x03, buffer empty.
// A stall on o_out holds the buffer and holds off i_in; configuration is never stalled.
`include "assert_macros.svh"

module info_frame_stuffing_framer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ifsf_chan_if.sink    i_in,
    ifsf_chan_if.sink    i_cfg,
    ifsf_chan_if.source  o_out
);

    ifsf_pkg::t_load ld;
    logic            free;

    ifsf_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_free  (free),
        .o_load  (ld)
    );

    ifsf_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld),
        .o_free  (free),
        .o_out   (o_out)
    );

    // Checks on buffer handoff and frame closing
    `AST_IMPLY(a_load_on_payload, i_in.valid && i_in.ready && i_in.data.action == ifsf_pkg::ACT_PAYLOAD, ld.load, "payload transaction did not load the buffer")
    `AST_IMPLY(a_no_overwrite, ld.load, !o_out.valid || (o_out.ready && o_out.data.run_last), "buffer reloaded while bytes remain")
    `AST_IMPLY(a_load_count, ld.load, ld.cnt != '0 && ld.cnt <= ifsf_pkg::CNT_W'(ifsf_pkg::MAX_RESULTS), "result count out of range")
    `AST_IMPLY(a_flag_is_last, o_out.valid && o_out.data.frame_end, o_out.data.run_last && o_out.data.out_byte == ifsf_pkg::FLAG_BYTE, "closing flag not last result")
    `AST_NEXT(a_load_shows, ld.load, o_out.valid, "loaded set not presented")

endmodule

// ----- dv/info_frame_stuffing_framer_unit_tb.sv -----
// Testbench for info_frame_stuffing_framer_unit: drives payload and acknowledge items and
// address writes, predicts the stuffed line bytes and checks every output byte in order.
// Depends on ifsf_pkg, ifsf_chan_if and the framer RTL.
`timescale 1ns / 100ps

// Predicts the line bytes of each payload transaction and checks them in order
class frame_scoreboard;
    ifsf_pkg::t_cfg       address;
    logic                 seq_bit;
    logic [7:0]           check_acc;
    bit                   frame_open;
    ifsf_pkg::t_out_item  line_q[$];
    int                   fault_count;

    function new();
        address     = ifsf_pkg::ADDR_RESET;
        seq_bit     = 1'b0;
        check_acc   = 8'h00;
        frame_open  = 1'b0;
        fault_count = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic fend);
        ifsf_pkg::t_out_item e;
        e.out_byte  = b;
        e.frame_end = fend;
        e.run_last  = 1'b0;
        line_q.push_back(e);
    endfunction

    // Escape flag and escape bytes on the line
    function void push_stuffed(logic [7:0] b);
        if (b == ifsf_pkg::FLAG_BYTE || b == ifsf_pkg::ESC_BYTE) begin
            push_byte(ifsf_pkg::ESC_BYTE, 1'b0);
            push_byte(b ^ ifsf_pkg::ESC_XOR, 1'b0);
        end else begin
            push_byte(b, 1'b0);
        end
    endfunction

    function void note_item(ifsf_pkg::t_in_item it);
        logic [7:0]           ctrl;
        ifsf_pkg::t_out_item  tail;
        // Acknowledge: flip the sequence bit, emit nothing
        if (it.action == ifsf_pkg::ACT_ACK) begin
            seq_bit = ~seq_bit;
            return;
        end
        // Open a frame: header goes out unstuffed
        if (!frame_open) begin
            ctrl = {1'b0, seq_bit, 6'b0};
            push_byte(ifsf_pkg::FLAG_BYTE, 1'b0);
            push_byte(address, 1'b0);
            push_byte(ctrl, 1'b0);
            push_byte(address ^ ctrl, 1'b0);
            check_acc  = 8'h00;
            frame_open = 1'b1;
        end
        push_stuffed(it.data_byte);
        check_acc = check_acc ^ it.data_byte;
        // Close the frame: stuffed check byte, then closing flag
        if (it.last_payload) begin
            push_stuffed(check_acc);
            push_byte(ifsf_pkg::FLAG_BYTE, 1'b1);
            check_acc  = 8'h00;
            frame_open = 1'b0;
        end
        tail = line_q.pop_back();
        tail.run_last = 1'b1;
        line_q.push_back(tail);
    endfunction

    function void report(string what, ifsf_pkg::t_out_item want, ifsf_pkg::t_out_item got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: expected byte %h end %b last %b, got byte %h end %b last %b",
                     $time, what, want.out_byte, want.frame_end, want.run_last,
                     got.out_byte, got.frame_end, got.run_last);
    endfunction

    function void check_byte(ifsf_pkg::t_out_item got);
        ifsf_pkg::t_out_item want;
        if (line_q.size() == 0) begin
            want = '0;
            report("unexpected output transaction", want, got);
            return;
        end
        want = line_q.pop_front();
        if (got !== want)
            report("line byte mismatch", want, got);
    endfunction

    function int pending();
        return line_q.size();
    endfunction
endclass

module info_frame_stuffing_framer_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 110;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cycle_cnt;

    frame_scoreboard sb;

    ifsf_chan_if #(.T(ifsf_pkg::t_in_item))  in_ch ();
    ifsf_chan_if #(.T(ifsf_pkg::t_cfg))      cfg_ch ();
    ifsf_chan_if #(.T(ifsf_pkg::t_out_item)) out_ch ();

    info_frame_stuffing_framer_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the line side at random
    always @(posedge clk) begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every accepted line byte
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_byte(out_ch.data);
    end

    // Bound the run
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("info_frame_stuffing_framer_unit_tb NOT OK");
        $finish;
    end

    function automatic ifsf_pkg::t_in_item pack_item(logic act, logic [7:0] d, logic l);
        ifsf_pkg::t_in_item it;
        it.action       = act;
        it.data_byte    = d;
        it.last_payload = l;
        return it;
    endfunction

    // Favor flag and escape values so stuffing is hit often
    function automatic logic [7:0] random_line_data();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return ifsf_pkg::FLAG_BYTE;
        else if (r < 24)
            return ifsf_pkg::ESC_BYTE;
        return 8'($urandom_range(255));
    endfunction

    // Present one item, idling first at random; hold valid until the transaction
    task automatic send_item(input ifsf_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(it);
    endtask

    // Drop valid and wait until every predicted byte is out, then let the block settle
    task automatic wait_line_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_address(input ifsf_pkg::t_cfg v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.address = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus acknowledges and broken frames
    task automatic send_random(input int count);
        int                 sent;
        int                 frame_left;
        int                 r;
        logic               l;
        ifsf_pkg::t_in_item it;
        sent       = 0;
        frame_left = 0;
        while (sent < count) begin
            // Pause the sender until the line drains, then move the address
            if (sent == count / 2) begin
                wait_line_idle();
                write_address(ifsf_pkg::t_cfg'($urandom_range(255)));
            end
            r = $urandom_range(99);
            if (r < 7) begin
                it = pack_item(ifsf_pkg::ACT_ACK, 8'($urandom_range(255)),
                               1'($urandom_range(1)));
            end else if (r < 11) begin
                l  = 1'($urandom_range(1));
                it = pack_item(ifsf_pkg::ACT_PAYLOAD, 8'($urandom_range(255)), l);
                if (l)
                    frame_left = 0;
            end else begin
                if (frame_left == 0)
                    frame_left = ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                           : $urandom_range(6, 1);
                it = pack_item(ifsf_pkg::ACT_PAYLOAD, random_line_data(), frame_left == 1);
                frame_left--;
            end
            send_item(it);
            sent++;
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 9;
        recv_idle_pct = 46;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset address; field extremes and stuffed payload bytes in one frame
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h00, 1'b0));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'hFF, 1'b0));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, ifsf_pkg::FLAG_BYTE, 1'b0));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, ifsf_pkg::ESC_BYTE, 1'b0));
        // Acknowledge inside an open frame leaves its header alone
        send_item(pack_item(ifsf_pkg::ACT_ACK, 8'hFF, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h01, 1'b1));
        // Single-byte frame with both payload and check escaped
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, ifsf_pkg::FLAG_BYTE, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_ACK, 8'h00, 1'b0));
        // Check byte lands on flag, then on escape
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h5A, 1'b0));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h24, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h12, 1'b0));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h6F, 1'b1));
        wait_line_idle();

        // Address equal to flag: header bytes go out unescaped
        write_address(ifsf_pkg::FLAG_BYTE);
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'hAA, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_ACK, 8'h00, 1'b0));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h55, 1'b0));
        wait_line_idle();

        // Address change while a frame is open only affects the next header
        write_address(ifsf_pkg::ESC_BYTE);
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, ifsf_pkg::ESC_BYTE, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h00, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_ACK, 8'h80, 1'b1));
        send_item(pack_item(ifsf_pkg::ACT_PAYLOAD, 8'h7F, 1'b1));
        wait_line_idle();

        // Random phases across idle mixes and address settings
        write_address(8'h00);
        send_random(ITEMS_PER_PHASE);
        wait_line_idle();

        send_idle_pct = 46;
        recv_idle_pct = 9;
        write_address(8'hFF);
        send_random(ITEMS_PER_PHASE);
        wait_line_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_address(ifsf_pkg::t_cfg'($urandom_range(255)));
        send_random(ITEMS_PER_PHASE);
        wait_line_idle();
        repeat (10) @(posedge clk);

        if (sb.fault_count == 0 && sb.pending() == 0) begin
            $display("info_frame_stuffing_framer_unit_tb OK");
        end else begin
            $display("info_frame_stuffing_framer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ifsf_pkg.sv
hdl/ifsf_chan_if.sv
hdl/ifsf_builder.sv
hdl/ifsf_serializer.sv
hdl/info_frame_stuffing_framer_unit.sv
dv/info_frame_stuffing_framer_unit_tb.sv
